// ===== rtl/cep_pkg.sv =====
// Types and constants for the connection element parser.
// No dependencies; imported by connection_element_parser.
package cep_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CNT_W       = 5;
  localparam int TOTAL_W     = 9;
  localparam int LEN_CMP_W   = 6;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_TYPE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_TYPE  = 8'd1;

  // Mask bits that enable the optional fields
  localparam logic [7:0] BIT_V4    = 8'b0100_0000;
  localparam logic [7:0] BIT_V6    = 8'b0010_0000;
  localparam logic [7:0] BIT_PORT  = 8'b0001_0000;
  localparam logic [7:0] BIT_BSSID = 8'b0000_1000;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_MEDIUM = 3'd2,
    PH_MASK   = 3'd3,
    PH_ADDR   = 3'd4,
    PH_PORT   = 3'd5,
    PH_BSSID  = 3'd6,
    PH_ACTION = 3'd7
  } phase_t;

  localparam logic [3:0] TAG_IGNORED = 4'd8;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_TYPE      = 4'd2;
  localparam logic [3:0] ST_LENGTH    = 4'd3;
  localparam logic [3:0] ST_MEDIUM    = 4'd4;
  localparam logic [3:0] ST_BOTH      = 4'd5;
  localparam logic [3:0] ST_V4        = 4'd6;
  localparam logic [3:0] ST_V6        = 4'd7;
  localparam logic [3:0] ST_PORT      = 4'd8;
  localparam logic [3:0] ST_BSSID     = 4'd9;
  localparam logic [3:0] ST_NO_ACTION = 4'd10;

  typedef struct packed {
    logic       type_err;
    logic       medium_err;
    logic       both_err;
  } err_flags_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] field_tag;
    logic       out_last;
    logic [3:0] frame_status;
  } out_beat_t;

  // First enabled optional field after phase 'from'; action when none is left.
  function automatic phase_t next_field(input phase_t from, input logic [7:0] mask);
    phase_t res;
    if (from < PH_ADDR && (mask & (BIT_V4 | BIT_V6)) != 8'd0) begin
      res = PH_ADDR;
    end else if (from < PH_PORT && (mask & BIT_PORT) != 8'd0) begin
      res = PH_PORT;
    end else if (from < PH_BSSID && (mask & BIT_BSSID) != 8'd0) begin
      res = PH_BSSID;
    end else begin
      res = PH_ACTION;
    end
    return res;
  endfunction

endpackage

// ===== rtl/connection_element_parser.sv =====
// Connection element parser: tags each frame byte, reports status on the last.
// Depends on cep_pkg.
//
// Result beats are registered: an accepted input beat shows at the output in the next cycle.
// Throughput: one beat per cycle; the output register decouples the sides,
// so input stalls only while a held result is itself stalled.
// Reset (rst, synchronous): clears frame state, both type registers and out_valid.
module connection_element_parser #(
  parameter int MIN_FRAME   = 5,
  parameter int V4_LEN      = 4,
  parameter int V6_LEN      = 16,
  parameter int PORT_BYTES  = 2,
  parameter int BSSID_BYTES = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cep_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cep_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import cep_pkg::*;

  localparam logic [LEN_CMP_W-1:0] V4_L    = LEN_CMP_W'(V4_LEN);
  localparam logic [LEN_CMP_W-1:0] V6_L    = LEN_CMP_W'(V6_LEN);
  localparam logic [LEN_CMP_W-1:0] PORT_L  = LEN_CMP_W'(PORT_BYTES);
  localparam logic [LEN_CMP_W-1:0] BSSID_L = LEN_CMP_W'(BSSID_BYTES);
  localparam logic [TOTAL_W-1:0]   MIN_T   = TOTAL_W'(MIN_FRAME);
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;

  logic [7:0] element_type_code;
  logic [7:0] medium_type_code;

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   field_count, field_count_next;
  logic [TOTAL_W-1:0] byte_total, byte_total_next;
  logic [7:0]         length_seen, length_seen_next;
  logic [7:0]         mask_seen, mask_seen_next;
  err_flags_t         error_flags, error_flags_next;
  logic               action_seen, action_seen_next;

  logic               accept;
  logic [3:0]         tag;
  logic [3:0]         status;
  logic [LEN_CMP_W-1:0] cur_len;
  logic [TOTAL_W:0]   len_plus2;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    unique case (phase)
      PH_ADDR:  cur_len = ((mask_seen & BIT_V4) != 8'd0) ? V4_L : V6_L;
      PH_PORT:  cur_len = PORT_L;
      default:  cur_len = BSSID_L;
    endcase
  end

  // Per-byte update of the frame state
  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    length_seen_next = length_seen;
    mask_seen_next   = mask_seen;
    error_flags_next = error_flags;
    action_seen_next = action_seen;
    byte_total_next  = (byte_total != TOTAL_MAX) ? byte_total + 1'b1 : byte_total;
    tag              = {1'b0, phase};

    if (error_flags.both_err) begin
      tag = TAG_IGNORED;
    end else begin
      unique case (phase)
        PH_TYPE: begin
          if (in_data.in_byte != element_type_code) error_flags_next.type_err = 1'b1;
          phase_next = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_seen_next = in_data.in_byte;
          phase_next       = PH_MEDIUM;
        end
        PH_MEDIUM: begin
          if (in_data.in_byte != medium_type_code) error_flags_next.medium_err = 1'b1;
          phase_next = PH_MASK;
        end
        PH_MASK: begin
          mask_seen_next = in_data.in_byte;
          if ((in_data.in_byte & BIT_V4) != 8'd0 && (in_data.in_byte & BIT_V6) != 8'd0) begin
            error_flags_next.both_err = 1'b1;
          end else begin
            phase_next = next_field(PH_MASK, in_data.in_byte);
          end
          field_count_next = '0;
        end
        PH_ADDR, PH_PORT, PH_BSSID: begin
          if ({1'b0, field_count} + 1'b1 >= cur_len) begin
            field_count_next = '0;
            phase_next       = next_field(phase, mask_seen);
          end else begin
            field_count_next = field_count + 1'b1;
          end
        end
        default: begin
          action_seen_next = 1'b1;
        end
      endcase
    end
  end

  // Status on the last byte, first failing check wins
  assign len_plus2 = {2'b00, length_seen_next} + (TOTAL_W+1)'(2);

  always_comb begin
    if (byte_total_next < MIN_T || byte_total_next < TOTAL_W'(4)) begin
      status = ST_SHORT;
    end else if (error_flags_next.type_err) begin
      status = ST_TYPE;
    end else if (len_plus2 != {1'b0, byte_total_next}) begin
      status = ST_LENGTH;
    end else if (error_flags_next.medium_err) begin
      status = ST_MEDIUM;
    end else if (error_flags_next.both_err) begin
      status = ST_BOTH;
    end else if (phase_next == PH_ADDR) begin
      status = ((mask_seen_next & BIT_V4) != 8'd0) ? ST_V4 : ST_V6;
    end else if (phase_next == PH_PORT) begin
      status = ST_PORT;
    end else if (phase_next == PH_BSSID) begin
      status = ST_BSSID;
    end else if (!action_seen_next) begin
      status = ST_NO_ACTION;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type_code <= '0;
      medium_type_code  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ELEMENT_TYPE) element_type_code <= cfg_data;
      if (cfg_index == REG_MEDIUM_TYPE)  medium_type_code  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      field_count <= '0;
      byte_total  <= '0;
      length_seen <= '0;
      mask_seen   <= '0;
      error_flags <= '0;
      action_seen <= 1'b0;
    end else if (accept) begin
      if (in_data.in_last) begin
        // drop frame state so the next beat opens a new frame
        phase       <= PH_TYPE;
        field_count <= '0;
        byte_total  <= '0;
        length_seen <= '0;
        mask_seen   <= '0;
        error_flags <= '0;
        action_seen <= 1'b0;
      end else begin
        phase       <= phase_next;
        field_count <= field_count_next;
        byte_total  <= byte_total_next;
        length_seen <= length_seen_next;
        mask_seen   <= mask_seen_next;
        error_flags <= error_flags_next;
        action_seen <= action_seen_next;
      end
    end
  end

  // Output register: hold while stalled, advance on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.out_byte     <= in_data.in_byte;
      out_data.field_tag    <= tag;
      out_data.out_last     <= in_data.in_last;
      out_data.frame_status <= in_data.in_last ? status : ST_OK;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for connection_element_parser: byte-stream frames, tags and status.
// Depends on cep_pkg (rtl/cep_pkg.sv) and the parser RTL; everything else is local.
// A local predictor computes each expected result beat; a monitor checks them in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cep_pkg::*;

  localparam int MIN_FRAME   = 5;
  localparam int V4_LEN      = 4;
  localparam int V6_LEN      = 16;
  localparam int PORT_BYTES  = 2;
  localparam int BSSID_BYTES = 6;
  localparam int CYCLE_LIMIT = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_beat_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  connection_element_parser #(
    .MIN_FRAME  (MIN_FRAME),
    .V4_LEN     (V4_LEN),
    .V6_LEN     (V6_LEN),
    .PORT_BYTES (PORT_BYTES),
    .BSSID_BYTES(BSSID_BYTES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser copy: register values and per-frame state
  logic [7:0] type_code   = 8'h00;
  logic [7:0] medium_code = 8'h00;
  phase_t     cur_phase   = PH_TYPE;
  logic [4:0] fcount      = '0;
  logic [8:0] total       = '0;
  logic [7:0] len_byte    = '0;
  logic [7:0] mask_byte   = '0;
  err_flags_t errs        = '0;
  logic       act_seen    = 1'b0;

  out_beat_t  tagged_q[$];
  logic [7:0] frame_q[$];
  int         mismatches    = 0;
  int         cycles        = 0;
  int         bytes_sent    = 0;
  int         in_gap_max    = 0;
  int         out_stall_max = 0;
  int         stall_left    = 0;

  // Append one byte at the tail of the frame being built
  function automatic void frame_add(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  // Append one expected result beat at the tail of the check queue
  function automatic void expect_add(out_beat_t r);
    tagged_q.insert(tagged_q.size(), r);
  endfunction

  function automatic phase_t after_field(phase_t from);
    if (from < PH_ADDR && (mask_byte & (BIT_V4 | BIT_V6)) != 8'd0) begin
      return PH_ADDR;
    end
    if (from < PH_PORT && (mask_byte & BIT_PORT) != 8'd0) begin
      return PH_PORT;
    end
    if (from < PH_BSSID && (mask_byte & BIT_BSSID) != 8'd0) begin
      return PH_BSSID;
    end
    return PH_ACTION;
  endfunction

  function automatic int field_bytes(phase_t p);
    if (p == PH_ADDR) begin
      return ((mask_byte & BIT_V4) != 8'd0) ? V4_LEN : V6_LEN;
    end
    if (p == PH_PORT) begin
      return PORT_BYTES;
    end
    return BSSID_BYTES;
  endfunction

  function automatic logic [3:0] frame_outcome();
    if (int'(total) < MIN_FRAME || total < 9'd4) begin
      return ST_SHORT;
    end
    if (errs.type_err) begin
      return ST_TYPE;
    end
    if (int'(len_byte) + 2 != int'(total)) begin
      return ST_LENGTH;
    end
    if (errs.medium_err) begin
      return ST_MEDIUM;
    end
    if (errs.both_err) begin
      return ST_BOTH;
    end
    if (cur_phase == PH_ADDR) begin
      return ((mask_byte & BIT_V4) != 8'd0) ? ST_V4 : ST_V6;
    end
    if (cur_phase == PH_PORT) begin
      return ST_PORT;
    end
    if (cur_phase == PH_BSSID) begin
      return ST_BSSID;
    end
    if (!act_seen) begin
      return ST_NO_ACTION;
    end
    return ST_OK;
  endfunction

  function automatic void clear_frame_state();
    cur_phase = PH_TYPE;
    fcount    = '0;
    total     = '0;
    len_byte  = '0;
    mask_byte = '0;
    errs      = '0;
    act_seen  = 1'b0;
  endfunction

  function automatic out_beat_t parse_byte(logic [7:0] b, logic last);
    out_beat_t r;
    if (total != 9'd511) begin
      total = total + 9'd1;
    end
    r.out_byte     = b;
    r.out_last     = last;
    r.frame_status = ST_OK;
    if (errs.both_err) begin
      r.field_tag = TAG_IGNORED;
    end else begin
      r.field_tag = {1'b0, cur_phase};
      case (cur_phase)
        PH_TYPE: begin
          if (b != type_code) errs.type_err = 1'b1;
          cur_phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_byte  = b;
          cur_phase = PH_MEDIUM;
        end
        PH_MEDIUM: begin
          if (b != medium_code) errs.medium_err = 1'b1;
          cur_phase = PH_MASK;
        end
        PH_MASK: begin
          mask_byte = b;
          if ((b & BIT_V4) != 8'd0 && (b & BIT_V6) != 8'd0) begin
            errs.both_err = 1'b1;
          end else begin
            cur_phase = after_field(PH_MASK);
          end
          fcount = '0;
        end
        PH_ADDR, PH_PORT, PH_BSSID: begin
          if (int'(fcount) + 1 >= field_bytes(cur_phase)) begin
            fcount    = '0;
            cur_phase = after_field(cur_phase);
          end else begin
            fcount = fcount + 5'd1;
          end
        end
        default: begin
          act_seen = 1'b1;
        end
      endcase
    end
    if (last) begin
      r.frame_status = frame_outcome();
      clear_frame_state();
    end
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Check result beats first, then apply register writes, then predict input beats
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (tagged_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual byte %h tag %0d",
                   $time, out_data.out_byte, out_data.field_tag);
          mismatches++;
        end else begin
          want = tagged_q.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("field_tag", want.field_tag, out_data.field_tag);
          check_field("out_last", want.out_last, out_data.out_last);
          check_field("frame_status", want.frame_status, out_data.frame_status);
        end
        stall_left = $urandom_range(0, out_stall_max);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ELEMENT_TYPE: type_code = cfg_data;
          REG_MEDIUM_TYPE:  medium_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expect_add(parse_byte(in_data.in_byte, in_data.in_last));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    int       gap;
    in_beat_t beat;
    gap          = $urandom_range(0, in_gap_max);
    beat.in_byte = b;
    beat.in_last = last;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (tagged_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (tagged_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0", $time, tagged_q.size());
      mismatches++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send n bytes of a packed word, most significant byte first
  task automatic send_bytes(input logic [47:0] word, input int n);
    for (int i = 0; i < n; i++) begin
      send_beat(word[8*(n-1-i) +: 8], i == n - 1);
    end
  endtask

  task automatic send_frame(input int pause_at);
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) settle();
      send_beat(frame_q[i], i == n - 1);
    end
  endtask

  function automatic int pace_choice();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 16;
    endcase
  endfunction

  task automatic pick_pacing();
    in_gap_max    = pace_choice();
    out_stall_max = pace_choice();
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one frame in frame_q; damaged frames carry one header or size defect
  task automatic make_frame(input bit damaged);
    logic [7:0] mask;
    int         cut;
    mask = rand_byte() & ~(BIT_V4 | BIT_V6);
    case ($urandom_range(0, 6))
      0, 1:    ;
      2, 3:    mask = mask | BIT_V4;
      4, 5:    mask = mask | BIT_V6;
      default: mask = mask | BIT_V4 | BIT_V6;
    endcase
    frame_q.delete();
    frame_add(type_code);
    frame_add(8'h00);
    frame_add(medium_code);
    frame_add(mask);
    if ((mask & (BIT_V4 | BIT_V6)) != 8'd0) begin
      repeat (((mask & BIT_V4) != 8'd0) ? V4_LEN : V6_LEN) frame_add(rand_byte());
    end
    if ((mask & BIT_PORT) != 8'd0) begin
      repeat (PORT_BYTES) frame_add(rand_byte());
    end
    if ((mask & BIT_BSSID) != 8'd0) begin
      repeat (BSSID_BYTES) frame_add(rand_byte());
    end
    repeat ($urandom_range(0, 4)) frame_add(rand_byte());
    frame_q[1] = 8'(frame_q.size() - 2);
    if (damaged) begin
      case ($urandom_range(0, 4))
        0: frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
        1: frame_q[1] = frame_q[1] ^ 8'($urandom_range(1, 255));
        2: frame_q[2] = frame_q[2] ^ 8'($urandom_range(1, 255));
        3: begin
          // cut bytes off the tail, then fix the length so a cut field error shows
          cut = $urandom_range(1, frame_q.size() - 1);
          repeat (cut) void'(frame_q.pop_back());
          if (frame_q.size() >= 2) frame_q[1] = 8'(frame_q.size() - 2);
        end
        default: begin
          repeat ($urandom_range(1, 3)) frame_add(rand_byte());
        end
      endcase
    end
  endtask

  task automatic make_noise();
    frame_q.delete();
    repeat ($urandom_range(1, 12)) frame_add(rand_byte());
  endtask

  task automatic test_directed_edges();
    in_gap_max    = 0;
    out_stall_max = 0;
    send_bytes(48'h00_03_00_00_aa, 5);       // minimal frame, reset codes
    send_bytes(48'hff, 1);                   // one byte only
    in_gap_max    = 3;
    out_stall_max = 3;
    send_bytes(48'h00_02_00_00, 4);          // full header, below minimum size
    send_bytes(48'h00_04_00_60_11_22, 6);    // both address bits
    send_bytes(48'h00_ff_00_00_00, 5);       // length byte at maximum
    send_bytes(48'h00_03_01_00_ff, 5);       // medium mismatch
  endtask

  task automatic test_well_formed_frames();
    int stop;
    int frames;
    stop   = bytes_sent + 300;
    frames = 0;
    while (bytes_sent < stop) begin
      pick_pacing();
      make_frame(1'b0);
      // hold the sender once mid-frame until the result side is empty
      send_frame(frames == 2 ? 2 : -1);
      frames++;
    end
  endtask

  task automatic test_broken_frames();
    int stop;
    stop = bytes_sent + 250;
    while (bytes_sent < stop) begin
      pick_pacing();
      make_frame($urandom_range(0, 1) == 1);
      send_frame(-1);
    end
  endtask

  task automatic test_register_sweep();
    logic [7:0] types[4];
    logic [7:0] mediums[4];
    int         stop;
    types   = '{8'hff, 8'h00, 8'hff, rand_byte()};
    mediums = '{8'h00, 8'hff, 8'hff, rand_byte()};
    for (int s = 0; s < 4; s++) begin
      settle();
      write_reg(REG_ELEMENT_TYPE, types[s]);
      write_reg(REG_MEDIUM_TYPE, mediums[s]);
      // indexes past the register map must be ignored
      write_reg((s == 0) ? 8'hff : 8'($urandom_range(2, 255)), rand_byte());
      stop = bytes_sent + 40;
      while (bytes_sent < stop) begin
        pick_pacing();
        if ($urandom_range(0, 4) == 0) begin
          make_noise();
        end else begin
          make_frame($urandom_range(0, 2) == 0);
        end
        send_frame(-1);
      end
    end
  endtask

  task automatic test_noise();
    int stop;
    stop = bytes_sent + 50;
    while (bytes_sent < stop) begin
      pick_pacing();
      make_noise();
      send_frame(-1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_well_formed_frames();
    test_broken_frames();
    test_register_sweep();
    test_noise();
    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cep_pkg.sv
rtl/connection_element_parser.sv
tb/sv/testbench.sv
